// ===== hw/rtl/vlc_pkg.sv =====
// Shared constants and types for the Vigenere letter cipher unit.
// No dependencies; imported by vigenere_letter_cipher_unit.
package vlc_pkg;

  localparam int unsigned MaxKeyLen  = 12;
  localparam int unsigned KeyLetterW = 5;
  localparam int unsigned KeyPosW    = 4;
  localparam int unsigned KeyLettersW = MaxKeyLen * KeyLetterW;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgAddrW   = 4;

  localparam logic [5:0] AlphaSize = 6'd26;

  // register index, taken from paddr[3] (8-byte register spacing)
  localparam logic RegKeyLetters = 1'b0;
  localparam logic RegKeyLength  = 1'b1;

  localparam logic ModeEncrypt = 1'b0;
  localparam logic ModeDecrypt = 1'b1;

  typedef logic [MaxKeyLen-1:0][KeyLetterW-1:0] key_letters_t;
  typedef logic [KeyPosW-1:0] key_pos_t;

  // first pipeline stage contents
  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
    logic       last;
    logic [4:0] shift;   // key letter number, 1..26
  } stage_t;

endpackage

// ===== hw/rtl/vigenere_letter_cipher_unit.sv =====
// Vigenere letter cipher unit: stream in, stream out, APB register port.
// Depends on vlc_pkg.
//
// Takes one ASCII byte per transaction and returns one result per transaction, one every
// cycle while the output is not stalled: the first register holds the byte together
// with the key letter picked by the running key position, the second holds the shifted
// upper-case letter. Letters A..Z / a..z are numbered 1..26, the key letter (stored 0..25)
// counts one more, and the sum (encrypt, tuser=0) or difference (decrypt, tuser=1) wraps
// within 1..26. Non-letters come back unchanged with the invalid flag in m_axis_tuser set.
// The key position steps once per transaction, wraps at key_length and restarts after a
// transaction with tlast. Registers: key_letters at 0x0 (twelve 5-bit letters, letter i in
// bits 5i+4:5i), key_length at 0x8 (values 0 and above 12 act as 1 and 12); write them only
// while no transaction is in flight.
module vigenere_letter_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
  input  logic                          s_axis_tuser,   // [0] mode
  input  logic                          s_axis_tlast,   // msg_end
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] char_out
  output logic                          m_axis_tuser,   // [0] invalid
  output logic                          m_axis_tlast,   // end_out
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vlc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [vlc_pkg::CfgDataW-1:0]  pwdata,
  output logic [vlc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import vlc_pkg::*;

  key_letters_t key_letters_q;
  key_pos_t     key_len_q;
  key_pos_t     key_pos_q, key_pos_d;
  key_pos_t     len_act, pos_act, pos_inc;

  logic         s1_valid_q;
  stage_t       s1_q, s1_d;
  logic         s1_adv, s_accept, cfg_wr;

  logic         m_valid_q;
  logic [7:0]   m_data_q, m_data_d;
  logic         m_inv_q, m_inv_d;
  logic         m_last_q;

  logic [4:0]   kval;
  logic [5:0]   num, sum, res;
  logic         is_upper, is_lower;

  // ---------------- register port ----------------
  // paddr[2:0] address bytes within a register and are not decoded
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_letters_q <= '0;
      key_len_q     <= key_pos_t'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3])
        RegKeyLetters: key_letters_q <= key_letters_t'(pwdata[KeyLettersW-1:0]);
        RegKeyLength:  key_len_q     <= pwdata[KeyPosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      RegKeyLetters: prdata = CfgDataW'(key_letters_q);
      RegKeyLength:  prdata = CfgDataW'(key_len_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // ---------------- key position and key letter ----------------
  always_comb begin
    if (key_len_q == '0) begin
      len_act = key_pos_t'(1);
    end else if (key_len_q > key_pos_t'(MaxKeyLen)) begin
      len_act = key_pos_t'(MaxKeyLen);
    end else begin
      len_act = key_len_q;
    end
    // position left beyond a shortened key restarts at the first letter
    pos_act = (key_pos_q >= len_act) ? '0 : key_pos_q;
    pos_inc = pos_act + key_pos_t'(1);
    key_pos_d = (pos_inc >= len_act || s_axis_tlast) ? '0 : pos_inc;

    kval = key_letters_q[pos_act];
    if (kval >= AlphaSize[4:0]) begin
      kval = kval - AlphaSize[4:0];
    end

    s1_d.mode    = s_axis_tuser;
    s1_d.char_in = s_axis_tdata;
    s1_d.last    = s_axis_tlast;
    s1_d.shift   = kval + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        key_pos_q <= key_pos_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q <= s1_d;
    end
  end

  // ---------------- letter shift ----------------
  always_comb begin
    is_upper = (s1_q.char_in >= 8'd65) && (s1_q.char_in <= 8'd90);
    is_lower = (s1_q.char_in >= 8'd97) && (s1_q.char_in <= 8'd122);
    priority if (is_upper) begin
      num = 6'(s1_q.char_in - 8'd64);
    end else if (is_lower) begin
      num = 6'(s1_q.char_in - 8'd96);
    end else begin
      num = '0;
    end

    unique case (s1_q.mode)
      ModeEncrypt: sum = num + {1'b0, s1_q.shift};
      ModeDecrypt: sum = num + AlphaSize - {1'b0, s1_q.shift};
      default:     sum = num;
    endcase
    res = (sum > AlphaSize) ? sum - AlphaSize : sum;

    m_inv_d  = !(is_upper || is_lower);
    m_data_d = m_inv_d ? s1_q.char_in : {2'b01, res};  // 64 + res
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      m_data_q <= m_data_d;
      m_inv_q  <= m_inv_d;
      m_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_inv_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------- assertions ----------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pos_q < key_pos_t'(MaxKeyLen))
    else $error("key position out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tlast |=> key_pos_q == '0)
    else $error("key position not restarted after last transaction");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_q.shift >= 5'd1) && (s1_q.shift <= AlphaSize[4:0]))
    else $error("key shift out of range");

  a_letter_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata >= 8'd65) && (m_axis_tdata <= 8'd90))
    else $error("valid result is not an upper-case letter");

endmodule
